// File: rtl/mexa_pkg.sv
// shared types and encodings for the mips execute alu
package mexa_pkg;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0a;
   localparam logic [5:0] OP_SLTIU   = 6'h0b;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_ORI     = 6'h0d;
   localparam logic [5:0] OP_LUI     = 6'h0f;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2b;

   // special funct codes
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLT  = 6'h2a;
   localparam logic [5:0] FN_SLTU = 6'h2b;

   localparam logic [31:0] SEXT_HIGH = 32'hffff_0000;
   localparam logic [31:0] BYTE_MASK = 32'h0000_00ff;
   localparam logic [31:0] HALF_MASK = 32'h0000_ffff;

   typedef enum logic [1:0] {
      SIZE_NONE = 2'd0,
      SIZE_BYTE = 2'd1,
      SIZE_HALF = 2'd2,
      SIZE_WORD = 2'd3
   } size_type;

   typedef enum logic [1:0] {
      EXC_NONE     = 2'd0,
      EXC_OVERFLOW = 2'd1,
      EXC_INVALID  = 2'd2
   } exc_type;

   typedef enum logic [3:0] {
      ALU_NONE,
      ALU_ADD,
      ALU_SUB,
      ALU_AND,
      ALU_OR,
      ALU_NOR,
      ALU_SLT,
      ALU_SLTU,
      ALU_SLL,
      ALU_SRL,
      ALU_LUI
   } alu_op_type;

   typedef enum logic [1:0] {
      SRC_REG,
      SRC_SEXT,
      SRC_ZEXT
   } src_type;

   typedef struct packed {
      alu_op_type op;
      src_type    src;
      logic       ovf_check;
      logic       reg_write;
      logic       mem_read;
      logic       mem_write;
      size_type   size;
      logic       invalid;
   } ctrl_type;

endpackage

// File: rtl/mips_execute_alu.sv
// top level of the mips execute alu: input register, decode and alu, result register
//
// One instruction word is taken per cycle while req_ready is high; it is held in the
// input register, then decode, alu and exception masking settle into the result
// register. The result register advances under a single stall condition, which the
// input register shares but also loads while empty, so full throughput of one word per
// cycle holds for as long as rsp_ready stays high; a low rsp_ready holds the two words in
// flight and drops req_ready only when both registers are occupied.
module mips_execute_alu import mexa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_alu_result,
   output logic [31:0] rsp_store_data,
   output logic [4:0]  rsp_dest_reg,
   output logic        rsp_reg_write,
   output logic        rsp_mem_read,
   output logic        rsp_mem_write,
   output logic [1:0]  rsp_access_size,
   output logic [1:0]  rsp_exception
);

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_instr_ff, s1_a_ff, s1_b_ff;
   logic        out_valid_ff, out_valid_in;
   logic        advance;

   ctrl_type    ctrl;
   logic [31:0] alu_value;
   logic        overflow;
   logic [4:0]  dest;
   exc_type     exc;

   logic [31:0] res_ff, res_in;
   logic [31:0] sdata_ff, sdata_in;
   logic [4:0]  dest_ff;
   logic        wr_ff, wr_in;
   logic        mr_ff, mr_in;
   logic        mw_ff, mw_in;
   size_type    size_ff, size_in;
   exc_type     exc_ff;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;

   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_instr_ff <= req_instruction;
         s1_a_ff     <= req_operand_a;
         s1_b_ff     <= req_operand_b;
      end
   end

   mexa_decode u_decode (
      .instruction (s1_instr_ff),
      .ctrl        (ctrl)
   );

   mexa_alu u_alu (
      .ctrl        (ctrl),
      .instruction (s1_instr_ff),
      .operand_a   (s1_a_ff),
      .operand_b   (s1_b_ff),
      .result      (alu_value),
      .overflow    (overflow)
   );

   assign dest = (s1_instr_ff[31:26] == OP_SPECIAL) ? s1_instr_ff[15:11] : s1_instr_ff[20:16];

   always_comb begin
      if (ctrl.invalid) begin
         exc = EXC_INVALID;
      end else if (overflow) begin
         exc = EXC_OVERFLOW;
      end else begin
         exc = EXC_NONE;
      end
   end

   always_comb begin
      res_in   = alu_value;
      wr_in    = ctrl.reg_write && (dest != 5'd0);
      mr_in    = ctrl.mem_read;
      mw_in    = ctrl.mem_write;
      size_in  = ctrl.size;
      sdata_in = '0;
      if (ctrl.mem_write) begin
         case (ctrl.size)
            SIZE_BYTE: sdata_in = s1_b_ff & BYTE_MASK;
            SIZE_HALF: sdata_in = s1_b_ff & HALF_MASK;
            default:   sdata_in = s1_b_ff;
         endcase
      end
      // any exception squashes the word
      if (exc != EXC_NONE) begin
         res_in   = '0;
         sdata_in = '0;
         wr_in    = 1'b0;
         mr_in    = 1'b0;
         mw_in    = 1'b0;
         size_in  = SIZE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         res_ff   <= res_in;
         sdata_ff <= sdata_in;
         dest_ff  <= dest;
         wr_ff    <= wr_in;
         mr_ff    <= mr_in;
         mw_ff    <= mw_in;
         size_ff  <= size_in;
         exc_ff   <= exc;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_alu_result  = res_ff;
   assign rsp_store_data  = sdata_ff;
   assign rsp_dest_reg    = dest_ff;
   assign rsp_reg_write   = wr_ff;
   assign rsp_mem_read    = mr_ff;
   assign rsp_mem_write   = mw_ff;
   assign rsp_access_size = size_ff;
   assign rsp_exception   = exc_ff;

   a_exc_squash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_exception != EXC_NONE) |->
         !rsp_reg_write && !rsp_mem_read && !rsp_mem_write && (rsp_alu_result == '0))
      else $error("exception word carries side effects");

   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_write |-> (rsp_dest_reg != 5'd0))
      else $error("write-back to register zero");

   a_store_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mem_write |-> (rsp_store_data == '0))
      else $error("store data set on a non-store");

   a_mem_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_mem_read || rsp_mem_write) == (rsp_access_size != SIZE_NONE))
                    && !(rsp_mem_read && rsp_mem_write))
      else $error("access size inconsistent with memory flags");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid && !rsp_ready |=> s1_valid_ff && $stable(s1_instr_ff))
      else $error("input register lost a word during stall");

endmodule

// File: rtl/mexa_decode.sv
// instruction decoder producing the alu control word
module mexa_decode import mexa_pkg::*; (
   input  logic [31:0] instruction,
   output ctrl_type    ctrl
);

   logic [5:0] opcode;
   logic [5:0] funct;

   assign opcode = instruction[31:26];
   assign funct  = instruction[5:0];

   always_comb begin
      ctrl = '{op: ALU_NONE, src: SRC_REG, ovf_check: 1'b0, reg_write: 1'b0,
               mem_read: 1'b0, mem_write: 1'b0, size: SIZE_NONE, invalid: 1'b0};
      case (opcode) inside
         OP_SPECIAL: begin
            ctrl.reg_write = 1'b1;
            case (funct)
               FN_ADD: begin
                  ctrl.op        = ALU_ADD;
                  ctrl.ovf_check = 1'b1;
               end
               FN_ADDU: ctrl.op = ALU_ADD;
               FN_SUB: begin
                  ctrl.op        = ALU_SUB;
                  ctrl.ovf_check = 1'b1;
               end
               FN_SUBU: ctrl.op = ALU_SUB;
               FN_AND:  ctrl.op = ALU_AND;
               FN_OR:   ctrl.op = ALU_OR;
               FN_NOR:  ctrl.op = ALU_NOR;
               FN_SLT:  ctrl.op = ALU_SLT;
               FN_SLTU: ctrl.op = ALU_SLTU;
               FN_SLL:  ctrl.op = ALU_SLL;
               FN_SRL:  ctrl.op = ALU_SRL;
               FN_JR:   ctrl.reg_write = 1'b0;
               default: begin
                  ctrl.reg_write = 1'b0;
                  ctrl.invalid   = 1'b1;
               end
            endcase
         end
         OP_ADDI: begin
            ctrl.op        = ALU_ADD;
            ctrl.src       = SRC_SEXT;
            ctrl.ovf_check = 1'b1;
            ctrl.reg_write = 1'b1;
         end
         OP_ADDIU: begin
            ctrl.op        = ALU_ADD;
            ctrl.src       = SRC_SEXT;
            ctrl.reg_write = 1'b1;
         end
         OP_SLTI: begin
            ctrl.op        = ALU_SLT;
            ctrl.src       = SRC_SEXT;
            ctrl.reg_write = 1'b1;
         end
         OP_SLTIU: begin
            ctrl.op        = ALU_SLTU;
            ctrl.src       = SRC_SEXT;
            ctrl.reg_write = 1'b1;
         end
         OP_ANDI: begin
            ctrl.op        = ALU_AND;
            ctrl.src       = SRC_ZEXT;
            ctrl.reg_write = 1'b1;
         end
         OP_ORI: begin
            ctrl.op        = ALU_OR;
            ctrl.src       = SRC_ZEXT;
            ctrl.reg_write = 1'b1;
         end
         OP_LUI: begin
            ctrl.op        = ALU_LUI;
            ctrl.reg_write = 1'b1;
         end
         OP_LBU, OP_LHU, OP_LW: begin
            ctrl.op        = ALU_ADD;
            ctrl.src       = SRC_SEXT;
            ctrl.reg_write = 1'b1;
            ctrl.mem_read  = 1'b1;
            ctrl.size      = (opcode == OP_LBU) ? SIZE_BYTE :
                             (opcode == OP_LHU) ? SIZE_HALF : SIZE_WORD;
         end
         OP_SB, OP_SH, OP_SW: begin
            ctrl.op        = ALU_ADD;
            ctrl.src       = SRC_SEXT;
            ctrl.mem_write = 1'b1;
            ctrl.size      = (opcode == OP_SB) ? SIZE_BYTE :
                             (opcode == OP_SH) ? SIZE_HALF : SIZE_WORD;
         end
         [OP_J:OP_BGTZ]: begin
            // control transfers pass through with no effect
         end
         default: ctrl.invalid = 1'b1;
      endcase
   end

endmodule

// File: rtl/mexa_alu.sv
// alu datapath with operand select and signed overflow detect
module mexa_alu import mexa_pkg::*; (
   input  ctrl_type    ctrl,
   input  logic [31:0] instruction,
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   output logic [31:0] result,
   output logic        overflow
);

   logic [15:0] imm;
   logic [4:0]  shamt;
   logic [31:0] src_b;
   logic [31:0] sum;
   logic [31:0] diff;

   assign imm   = instruction[15:0];
   assign shamt = instruction[10:6];

   always_comb begin
      case (ctrl.src)
         SRC_SEXT: src_b = imm[15] ? ({16'h0000, imm} | SEXT_HIGH) : {16'h0000, imm};
         SRC_ZEXT: src_b = {16'h0000, imm};
         default:  src_b = operand_b;
      endcase
   end

   assign sum  = operand_a + src_b;
   assign diff = operand_a - src_b;

   always_comb begin
      case (ctrl.op)
         ALU_ADD:  result = sum;
         ALU_SUB:  result = diff;
         ALU_AND:  result = operand_a & src_b;
         ALU_OR:   result = operand_a | src_b;
         ALU_NOR:  result = ~(operand_a | src_b);
         ALU_SLT:  result = {31'd0, $signed(operand_a) < $signed(src_b)};
         ALU_SLTU: result = {31'd0, operand_a < src_b};
         ALU_SLL:  result = src_b << shamt;
         ALU_SRL:  result = src_b >> shamt;
         ALU_LUI:  result = {imm, 16'h0000};
         default:  result = '0;
      endcase
   end

   always_comb begin
      overflow = 1'b0;
      if (ctrl.ovf_check) begin
         case (ctrl.op)
            ALU_ADD: overflow = ~(operand_a[31] ^ src_b[31]) & (operand_a[31] ^ sum[31]);
            ALU_SUB: overflow = (operand_a[31] ^ src_b[31]) & (operand_a[31] ^ diff[31]);
            default: overflow = 1'b0;
         endcase
      end
   end

endmodule
